@@ src/dfpa_pkg.sv @@
package dfpa_pkg;

   // decimal scale: one unit is one hundred hundredths
   localparam int unsigned SCALE = 100;
   localparam int unsigned HUND_BITS = 8;
   localparam int unsigned HUND_QBITS = 7;
   localparam int unsigned HUND_MAX = 99;

   typedef enum logic [1:0] {
      ACT_ADD = 2'd0,
      ACT_SUB = 2'd1,
      ACT_MUL = 2'd2,
      ACT_DIV = 2'd3
   } action_type;

   typedef struct packed {
      logic gt;
      logic lt;
      logic eq;
   } flags_type;

   // per-word status carried down the divider pipe
   typedef struct packed {
      logic      neg;
      logic      sat;
      logic      dz;
      flags_type flags;
   } side_type;

endpackage

@@ src/decimal_fixed_point_alu_top.sv @@
// Decimal fixed-point ALU on whole + hundredths operands. Each word is turned into an exact
// count of hundredths, then added, subtracted, multiplied (truncated back to hundredths) or
// divided (truncated toward zero); results that do not fit the whole part saturate with
// overflow set, a zero divisor gives zero with div_zero set. One word is accepted every cycle
// while no result waits at the output. The restoring divider resolves one quotient bit per
// pipeline stage (WHOLE_BITS stages for the whole part, seven more for the hundredths). The
// whole pipe holds while a result waits on rsp_ready, so nothing is dropped or repeated.
module decimal_fixed_point_alu_top #(
   parameter int WHOLE_BITS = 24
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [1:0]                              req_action,
   input  logic signed [WHOLE_BITS-1:0]            req_a_whole,
   input  logic signed [dfpa_pkg::HUND_BITS-1:0]   req_a_hundredths,
   input  logic signed [WHOLE_BITS-1:0]            req_b_whole,
   input  logic signed [dfpa_pkg::HUND_BITS-1:0]   req_b_hundredths,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [WHOLE_BITS-1:0]            rsp_r_whole,
   output logic signed [dfpa_pkg::HUND_BITS-1:0]   rsp_r_hundredths,
   output logic                                    rsp_a_greater,
   output logic                                    rsp_a_less,
   output logic                                    rsp_both_equal,
   output logic                                    rsp_div_zero,
   output logic                                    rsp_overflow
);
   import dfpa_pkg::*;

   localparam int W  = WHOLE_BITS;
   localparam int HB = HUND_BITS;
   localparam int HQ = HUND_QBITS;
   localparam int MW = W + 7;          // magnitude of a hundredths count or a sum
   localparam int RW = W + MW;         // dividend once saturation is ruled out
   localparam int PW = 2 * MW;         // full product
   localparam int HL = (MW + 1) / 2;   // low slice of the multiplier operand
   localparam int HH = MW - HL;
   localparam int SW = MW + 7;         // remainder times one hundred

   logic adv;
   logic rsp_valid_ff;

   // whole pipe moves unless a result is stuck at the output
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // stage 1: input register
   logic                 v1_ff;
   action_type           act1_ff;
   logic signed [W-1:0]  aw1_ff, bw1_ff;
   logic signed [HB-1:0] ah1_ff, bh1_ff;

   // stage 2: hundredth counts and compare flags
   logic                 v2_ff;
   action_type           act2_ff;
   logic signed [MW-1:0] va2_ff, vb2_ff, va2_in, vb2_in;
   flags_type            fl2_ff, fl2_in;

   // stage 3: sum or difference, magnitudes
   logic                 v3_ff;
   action_type           act3_ff;
   logic signed [MW:0]   r3_ff, r3_in;
   logic [MW-1:0]        ma3_ff, mb3_ff, ma3_in, mb3_in;
   logic                 nmd3_ff;
   flags_type            fl3_ff;

   // stage 4: partial products
   logic                 v4_ff;
   action_type           act4_ff;
   logic [MW-1:0]        ms4_ff, ms4_in, ma4_ff, mb4_ff;
   logic                 ns4_ff, nmd4_ff;
   logic [MW+HL-1:0]     pp0_ff, pp0_in;
   logic [MW+HH-1:0]     pp1_ff, pp1_in;
   flags_type            fl4_ff;

   // stage 5: full product
   logic                 v5_ff;
   action_type           act5_ff;
   logic [MW-1:0]        ms5_ff, ma5_ff, mb5_ff;
   logic                 ns5_ff, nmd5_ff;
   logic [PW-1:0]        p5_ff, p5_in;
   flags_type            fl5_ff;

   // divider pipe, index 0 is the operand select stage
   logic                 dv_ff [0:W];
   logic [RW-1:0]        dr_ff [0:W];
   logic [RW-1:0]        dr_in [0:W];
   logic [W-1:0]         dq_ff [0:W];
   logic [W-1:0]         dq_in [0:W];
   logic [MW-1:0]        dd_ff [0:W];
   side_type             ds_ff [0:W];
   side_type             ds0_in;

   // hundredths pipe, index 0 is the scaled remainder
   logic                 hv_ff [0:HQ];
   logic [SW-1:0]        hr_ff [0:HQ];
   logic [SW-1:0]        hr_in [0:HQ];
   logic [HQ-1:0]        hq_ff [0:HQ];
   logic [HQ-1:0]        hq_in [0:HQ];
   logic [W-1:0]         hw_ff [0:HQ];
   logic [MW-1:0]        hd_ff [0:HQ];
   side_type             hs_ff [0:HQ];

   // output register
   logic signed [W-1:0]  rw_ff, rw_in;
   logic signed [HB-1:0] rh_ff, rh_in;
   side_type             os_ff;
   logic                 ovf_ff, ovf_in;

   // stage 2 logic
   logic signed [MW-1:0] awx, bwx, ahx, bhx;
   always_comb begin
      awx    = MW'(aw1_ff);
      bwx    = MW'(bw1_ff);
      ahx    = MW'(ah1_ff);
      bhx    = MW'(bh1_ff);
      va2_in = (awx <<< 6) + (awx <<< 5) + (awx <<< 2) + ahx;
      vb2_in = (bwx <<< 6) + (bwx <<< 5) + (bwx <<< 2) + bhx;
      fl2_in.gt = (aw1_ff > bw1_ff) || ((aw1_ff == bw1_ff) && (ah1_ff > bh1_ff));
      fl2_in.lt = (aw1_ff < bw1_ff) || ((aw1_ff == bw1_ff) && (ah1_ff < bh1_ff));
      fl2_in.eq = (aw1_ff == bw1_ff) && (ah1_ff == bh1_ff);
   end

   // stage 3 logic
   always_comb begin
      if (act2_ff == ACT_ADD) begin
         r3_in = (MW+1)'(va2_ff) + (MW+1)'(vb2_ff);
      end else begin
         r3_in = (MW+1)'(va2_ff) - (MW+1)'(vb2_ff);
      end
      ma3_in = va2_ff[MW-1] ? $unsigned(-va2_ff) : $unsigned(va2_ff);
      mb3_in = vb2_ff[MW-1] ? $unsigned(-vb2_ff) : $unsigned(vb2_ff);
   end

   // stage 4 logic
   logic signed [MW:0] r3_neg;
   always_comb begin
      r3_neg = -r3_ff;
      ms4_in = r3_ff[MW] ? MW'($unsigned(r3_neg)) : MW'($unsigned(r3_ff));
      pp0_in = (MW+HL)'(ma3_ff) * (MW+HL)'(mb3_ff[HL-1:0]);
      pp1_in = (MW+HH)'(ma3_ff) * (MW+HH)'(mb3_ff[MW-1:HL]);
   end

   // stage 5 logic
   assign p5_in = PW'(pp0_ff) + (PW'(pp1_ff) << HL);

   // operand select and saturation check
   logic [PW-1:0] num, thr;
   logic [MW-1:0] den;
   logic          neg0;
   always_comb begin
      unique case (act5_ff)
         ACT_ADD, ACT_SUB: begin
            num  = PW'(ms5_ff);
            den  = MW'(SCALE);
            neg0 = ns5_ff;
         end
         ACT_MUL: begin
            num  = p5_ff;
            den  = MW'(SCALE * SCALE);
            neg0 = nmd5_ff;
         end
         ACT_DIV: begin
            num  = PW'(ma5_ff);
            den  = mb5_ff;
            neg0 = nmd5_ff;
         end
         default: begin
            num  = '0;
            den  = '0;
            neg0 = 1'b0;
         end
      endcase
      // whole part limit plus one, times the divisor
      thr          = (PW'(den) << (W - 1)) + (neg0 ? PW'(den) : '0);
      ds0_in.neg   = neg0;
      ds0_in.dz    = (act5_ff == ACT_DIV) && (mb5_ff == '0);
      ds0_in.sat   = (num >= thr) && !ds0_in.dz;
      ds0_in.flags = fl5_ff;
      dr_in[0]     = num[RW-1:0];
      dq_in[0]     = '0;
   end

   // front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         dv_ff[0] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         dv_ff[0] <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         act1_ff  <= action_type'(req_action);
         aw1_ff   <= req_a_whole;
         ah1_ff   <= req_a_hundredths;
         bw1_ff   <= req_b_whole;
         bh1_ff   <= req_b_hundredths;
         act2_ff  <= act1_ff;
         va2_ff   <= va2_in;
         vb2_ff   <= vb2_in;
         fl2_ff   <= fl2_in;
         act3_ff  <= act2_ff;
         r3_ff    <= r3_in;
         ma3_ff   <= ma3_in;
         mb3_ff   <= mb3_in;
         nmd3_ff  <= va2_ff[MW-1] ^ vb2_ff[MW-1];
         fl3_ff   <= fl2_ff;
         act4_ff  <= act3_ff;
         ms4_ff   <= ms4_in;
         ns4_ff   <= r3_ff[MW];
         ma4_ff   <= ma3_ff;
         mb4_ff   <= mb3_ff;
         nmd4_ff  <= nmd3_ff;
         pp0_ff   <= pp0_in;
         pp1_ff   <= pp1_in;
         fl4_ff   <= fl3_ff;
         act5_ff  <= act4_ff;
         ms5_ff   <= ms4_ff;
         ns5_ff   <= ns4_ff;
         ma5_ff   <= ma4_ff;
         mb5_ff   <= mb4_ff;
         nmd5_ff  <= nmd4_ff;
         p5_ff    <= p5_in;
         fl5_ff   <= fl4_ff;
         dr_ff[0] <= dr_in[0];
         dq_ff[0] <= dq_in[0];
         dd_ff[0] <= den;
         ds_ff[0] <= ds0_in;
      end
   end

   // whole part: one quotient bit per stage, msb first
   for (genvar j = 1; j <= W; j++) begin : g_div
      localparam int K = W - j;
      logic [RW-1:0] dsh;
      assign dsh = RW'(dd_ff[j-1]) << K;

      always_comb begin
         dr_in[j] = dr_ff[j-1];
         dq_in[j] = dq_ff[j-1];
         if (dr_ff[j-1] >= dsh) begin
            dr_in[j]    = dr_ff[j-1] - dsh;
            dq_in[j][K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_ff[j] <= dv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dr_ff[j] <= dr_in[j];
            dq_ff[j] <= dq_in[j];
            dd_ff[j] <= dd_ff[j-1];
            ds_ff[j] <= ds_ff[j-1];
         end
      end
   end

   // remainder times one hundred
   logic [SW-1:0] rem_x;
   always_comb begin
      rem_x    = SW'(dr_ff[W]);
      hr_in[0] = (rem_x << 6) + (rem_x << 5) + (rem_x << 2);
      hq_in[0] = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff[0] <= 1'b0;
      end else if (adv) begin
         hv_ff[0] <= dv_ff[W];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hr_ff[0] <= hr_in[0];
         hq_ff[0] <= hq_in[0];
         hw_ff[0] <= dq_ff[W];
         hd_ff[0] <= dd_ff[W];
         hs_ff[0] <= ds_ff[W];
      end
   end

   // hundredths: one quotient bit per stage
   for (genvar j = 1; j <= HQ; j++) begin : g_hund
      localparam int K = HQ - j;
      logic [SW-1:0] hsh;
      assign hsh = SW'(hd_ff[j-1]) << K;

      always_comb begin
         hr_in[j] = hr_ff[j-1];
         hq_in[j] = hq_ff[j-1];
         if (hr_ff[j-1] >= hsh) begin
            hr_in[j]    = hr_ff[j-1] - hsh;
            hq_in[j][K] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hv_ff[j] <= 1'b0;
         end else if (adv) begin
            hv_ff[j] <= hv_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            hr_ff[j] <= hr_in[j];
            hq_ff[j] <= hq_in[j];
            hw_ff[j] <= hw_ff[j-1];
            hd_ff[j] <= hd_ff[j-1];
            hs_ff[j] <= hs_ff[j-1];
         end
      end
   end

   // sign, saturation and zero divisor
   side_type      fin;
   logic [HB-1:0] hmag;
   always_comb begin
      fin  = hs_ff[HQ];
      hmag = HB'(hq_ff[HQ]);
      priority if (fin.dz) begin
         rw_in  = '0;
         rh_in  = '0;
         ovf_in = 1'b0;
      end else if (fin.sat) begin
         rw_in  = fin.neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
         rh_in  = fin.neg ? -HB'(HUND_MAX) : HB'(HUND_MAX);
         ovf_in = 1'b1;
      end else begin
         rw_in  = fin.neg ? -$signed(hw_ff[HQ]) : $signed(hw_ff[HQ]);
         rh_in  = fin.neg ? -$signed(hmag) : $signed(hmag);
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= hv_ff[HQ];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rw_ff  <= rw_in;
         rh_ff  <= rh_in;
         os_ff  <= fin;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_r_whole      = rw_ff;
   assign rsp_r_hundredths = rh_ff;
   assign rsp_a_greater    = os_ff.flags.gt;
   assign rsp_a_less       = os_ff.flags.lt;
   assign rsp_both_equal   = os_ff.flags.eq;
   assign rsp_div_zero     = os_ff.dz;
   assign rsp_overflow     = ovf_ff;

endmodule
